// ===== sv/led_blink_code_flasher_assert.svh =====
// Assertion macros for the LED blink-code flasher.
// Each check is sampled at the rising clock edge and is skipped while reset is high.
`ifndef LED_BLINK_CODE_FLASHER_ASSERT_SVH
`define LED_BLINK_CODE_FLASHER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that the consequent holds in the same cycle as the antecedent.
`define LBCF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("led flasher check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LBCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("led flasher check failed");

`else

`define LBCF_ASSERT_SAME(label, clk, rst, ante, cons)
`define LBCF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/ledbcf_pkg.sv =====
package ledbcf_pkg;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_MODE   = 2'd1,
    OP_ERROR_CODE = 2'd2,
    OP_FORCE_LED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DM_OFF       = 2'd0,
    DM_ON        = 2'd1,
    DM_HEARTBEAT = 2'd2,
    DM_ERROR     = 2'd3
  } dm_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_FLASH_ON  = 2'd1,
    PH_FLASH_GAP = 2'd2,
    PH_PAUSE     = 2'd3
  } phase_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_PAUSE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_HIGH_LIT = 3'd4;

  localparam logic [15:0] HB_PERIOD_RST   = 16'd1000;
  localparam logic [15:0] FLASH_ON_RST    = 16'd200;
  localparam logic [15:0] FLASH_GAP_RST   = 16'd200;
  localparam logic [15:0] GROUP_PAUSE_RST = 16'd1000;

  typedef struct packed {
    logic [15:0] hb_period;
    logic [15:0] on_time;
    logic [15:0] gap_time;
    logic [15:0] pause_time;
    logic        pin_high_lit;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] arg;
  } cmd_t;

  typedef struct packed {
    logic   led;
    dm_t    mode;
    phase_t phase;
  } res_t;

endpackage

// ===== sv/ledbcf_cfg.sv =====
module ledbcf_cfg
  import ledbcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hb_period    <= HB_PERIOD_RST;
      regs.on_time      <= FLASH_ON_RST;
      regs.gap_time     <= FLASH_GAP_RST;
      regs.pause_time   <= GROUP_PAUSE_RST;
      regs.pin_high_lit <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HB_PERIOD:    regs.hb_period    <= wr_data;
        REG_FLASH_ON:     regs.on_time      <= wr_data;
        REG_FLASH_GAP:    regs.gap_time     <= wr_data;
        REG_GROUP_PAUSE:  regs.pause_time   <= wr_data;
        REG_PIN_HIGH_LIT: regs.pin_high_lit <= wr_data[0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== sv/ledbcf_core.sv =====
module ledbcf_core
  import ledbcf_pkg::*;
#(
  parameter int TIME_BITS = 16
)(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output res_t res_next
);

  localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

  dm_t                  mode, mode_next;
  phase_t               phase, phase_next;
  logic                 led, led_next;
  logic [TIME_BITS-1:0] elapsed, elapsed_next;
  logic [7:0]           code, code_next;
  logic [7:0]           flashes_done, flashes_done_next;

  logic [TIME_BITS-1:0] el_tick;
  logic [15:0]          hb_half;
  logic                 ge_hb, ge_on, ge_gap, ge_pause;

  // saturating count, then compare at a common width
  assign el_tick  = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign hb_half  = cfg.hb_period >> 1;
  assign ge_hb    = CMP_W'(el_tick) >= CMP_W'(hb_half);
  assign ge_on    = CMP_W'(el_tick) >= CMP_W'(cfg.on_time);
  assign ge_gap   = CMP_W'(el_tick) >= CMP_W'(cfg.gap_time);
  assign ge_pause = CMP_W'(el_tick) >= CMP_W'(cfg.pause_time);

  always_comb begin
    mode_next         = mode;
    phase_next        = phase;
    led_next          = led;
    elapsed_next      = elapsed;
    code_next         = code;
    flashes_done_next = flashes_done;

    unique case (cmd.op)
      OP_TICK: begin
        elapsed_next = el_tick;
        if (mode == DM_HEARTBEAT) begin
          if ((cfg.hb_period != 16'd0) && ge_hb) begin
            elapsed_next = '0;
            led_next     = ~led;
          end
        end else if (mode == DM_ERROR) begin
          if (code == 8'd0) begin
            led_next = 1'b0;
          end else begin
            unique case (phase)
              PH_IDLE: begin
                flashes_done_next = 8'd0;
                phase_next        = PH_FLASH_ON;
                elapsed_next      = '0;
                led_next          = 1'b1;
              end
              PH_FLASH_ON: begin
                if (ge_on) begin
                  led_next          = 1'b0;
                  elapsed_next      = '0;
                  phase_next        = PH_FLASH_GAP;
                  flashes_done_next = flashes_done + 8'd1;
                end
              end
              PH_FLASH_GAP: begin
                if (ge_gap) begin
                  elapsed_next = '0;
                  if (flashes_done >= code) begin
                    phase_next = PH_PAUSE;
                  end else begin
                    phase_next = PH_FLASH_ON;
                    led_next   = 1'b1;
                  end
                end
              end
              PH_PAUSE: begin
                if (ge_pause) begin
                  phase_next        = PH_FLASH_ON;
                  elapsed_next      = '0;
                  flashes_done_next = 8'd0;
                  led_next          = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_SET_MODE: begin
        if (cmd.arg[7:2] == 6'd0) begin
          mode_next         = dm_t'(cmd.arg[1:0]);
          elapsed_next      = '0;
          phase_next        = PH_IDLE;
          flashes_done_next = 8'd0;
          if (dm_t'(cmd.arg[1:0]) == DM_ON)    led_next  = 1'b1;
          if (dm_t'(cmd.arg[1:0]) == DM_OFF)   led_next  = 1'b0;
          if (dm_t'(cmd.arg[1:0]) != DM_ERROR) code_next = 8'd0;
        end
      end
      OP_ERROR_CODE: begin
        elapsed_next      = '0;
        phase_next        = PH_IDLE;
        flashes_done_next = 8'd0;
        if (cmd.arg == 8'd0) begin
          // code zero turns the display off
          mode_next = DM_OFF;
          led_next  = 1'b0;
          code_next = 8'd0;
        end else begin
          mode_next = DM_ERROR;
          code_next = cmd.arg;
        end
      end
      OP_FORCE_LED: begin
        led_next = |cmd.arg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= DM_OFF;
      phase        <= PH_IDLE;
      led          <= 1'b0;
      elapsed      <= '0;
      code         <= 8'd0;
      flashes_done <= 8'd0;
    end else if (step) begin
      mode         <= mode_next;
      phase        <= phase_next;
      led          <= led_next;
      elapsed      <= elapsed_next;
      code         <= code_next;
      flashes_done <= flashes_done_next;
    end
  end

  assign res_next.led   = led_next;
  assign res_next.mode  = mode_next;
  assign res_next.phase = phase_next;

endmodule

// ===== sv/led_blink_code_flasher.sv =====
// LED blink-code flasher: drives one diagnostic LED from a stream of 1 ms ticks and
// commands (set display mode, flash an error code, force the LED level). Every request
// yields exactly one result carrying the logical LED state, the pin level after the
// polarity setting, the display mode and the flash phase. The block takes one request
// per clock cycle unless intake is stopped: the request is caught in an input register,
// the mode/timer update runs in one pass of compare and counter logic, and the result
// lands in an output register. A stalled output only stops intake once both registers
// are full. Timing registers are written through the configuration channel, which is
// always ready; write them only while no request is in flight. The elapsed timer is
// TIME_BITS wide and saturates.
`include "led_blink_code_flasher_assert.svh"

module led_blink_code_flasher
  import ledbcf_pkg::*;
#(
  parameter int TIME_BITS = 16
)(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [7:0]            arg,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  led_lit,
  output logic                  pin_level,
  output logic [1:0]            display_mode,
  output logic [1:0]            flash_phase,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res_next;
  logic cmd_valid;
  logic advance;

  // Configuration registers; writes never stall.
  assign cfg_ready = 1'b1;

  ledbcf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held request into the result register when that slot is free or
  // being drained this cycle.
  assign advance  = cmd_valid && (!out_valid || out_ready);
  assign in_ready = !cmd_valid || advance;

  // Input register: hold the request until it is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd.op  <= op_t'(mode);
      cmd.arg <= arg;
    end
  end

  // Mode, phase and timer update for one request.
  ledbcf_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .cmd      (cmd),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_lit      <= res_next.led;
      pin_level    <= cfg.pin_high_lit ? res_next.led : ~res_next.led;
      display_mode <= res_next.mode;
      flash_phase  <= res_next.phase;
    end
  end

  // Intake stops only when both the input and result registers are full and blocked.
  `LBCF_ASSERT_SAME(a_ready_low_only_when_full, clk, rst, !in_ready,
                    cmd_valid && out_valid && !out_ready)

  // A processed request always shows up as a result on the next cycle.
  `LBCF_ASSERT_NEXT(a_advance_gives_result, clk, rst, advance, out_valid)

  // The flash sequence only runs in error-code mode.
  `LBCF_ASSERT_SAME(a_phase_only_in_error, clk, rst,
                    out_valid && (flash_phase != 2'(PH_IDLE)),
                    display_mode == 2'(DM_ERROR))

endmodule

// ===== verif/led_blink_code_flasher_checker.sv =====
module led_blink_code_flasher_checker
  import ledbcf_pkg::*;
#(
  parameter int TIME_BITS = 16
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [7:0]            arg,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  led_lit,
  input  logic                  pin_level,
  input  logic [1:0]            display_mode,
  input  logic [1:0]            flash_phase,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   lit;
    logic   pin;
    dm_t    mode;
    phase_t ph;
  } lamp_view_t;

  lamp_view_t lamp_expect[$];

  // Shadow of the timing registers and of the indicator state.
  cfg_t                 regs;
  dm_t                  disp_mode;
  logic                 lamp_on;
  logic [TIME_BITS-1:0] tick_count;
  phase_t               blink_phase;
  logic [7:0]           shown_code;
  logic [7:0]           flashes_shown;

  function automatic bit reached(input logic [15:0] limit);
    return longint'(tick_count) >= longint'(limit);
  endfunction

  task automatic select_display(input dm_t m);
    disp_mode = m;
    if (m == DM_ON) lamp_on = 1'b1;
    if (m == DM_OFF) lamp_on = 1'b0;
    tick_count = '0;
    blink_phase = PH_IDLE;
    flashes_shown = '0;
    if (m != DM_ERROR) shown_code = '0;
  endtask

  task automatic service_code();
    if (shown_code == 8'd0) begin
      lamp_on = 1'b0;
    end else begin
      case (blink_phase)
        PH_IDLE: begin
          flashes_shown = '0;
          blink_phase = PH_FLASH_ON;
          tick_count = '0;
          lamp_on = 1'b1;
        end
        PH_FLASH_ON: begin
          if (reached(regs.on_time)) begin
            lamp_on = 1'b0;
            tick_count = '0;
            blink_phase = PH_FLASH_GAP;
            flashes_shown = flashes_shown + 8'd1;
          end
        end
        PH_FLASH_GAP: begin
          if (reached(regs.gap_time)) begin
            tick_count = '0;
            if (flashes_shown >= shown_code) begin
              blink_phase = PH_PAUSE;
            end else begin
              blink_phase = PH_FLASH_ON;
              lamp_on = 1'b1;
            end
          end
        end
        default: begin
          if (reached(regs.pause_time)) begin
            blink_phase = PH_FLASH_ON;
            tick_count = '0;
            flashes_shown = '0;
            lamp_on = 1'b1;
          end
        end
      endcase
    end
  endtask

  task automatic advance_lamp(input op_t op, input logic [7:0] a);
    lamp_view_t v;
    case (op)
      OP_TICK: begin
        if (tick_count != '1) tick_count = tick_count + 1'b1;
        if (disp_mode == DM_HEARTBEAT) begin
          if (regs.hb_period != 16'd0 && reached(regs.hb_period >> 1)) begin
            tick_count = '0;
            lamp_on = ~lamp_on;
          end
        end else if (disp_mode == DM_ERROR) begin
          service_code();
        end
      end
      OP_SET_MODE: begin
        if (a <= 8'd3) select_display(dm_t'(a[1:0]));
      end
      OP_ERROR_CODE: begin
        if (a == 8'd0) begin
          select_display(DM_OFF);
        end else begin
          shown_code = a;
          flashes_shown = '0;
          blink_phase = PH_IDLE;
          tick_count = '0;
          disp_mode = DM_ERROR;
        end
      end
      default: lamp_on = (a != 8'd0);
    endcase
    v.lit = lamp_on;
    v.pin = regs.pin_high_lit ? lamp_on : ~lamp_on;
    v.mode = disp_mode;
    v.ph = blink_phase;
    lamp_expect.push_back(v);
  endtask

  task automatic compare_field(input string what, input logic [1:0] want,
                               input logic [1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    lamp_view_t exp_v;
    if (rst) begin
      regs.hb_period = HB_PERIOD_RST;
      regs.on_time = FLASH_ON_RST;
      regs.gap_time = FLASH_GAP_RST;
      regs.pause_time = GROUP_PAUSE_RST;
      regs.pin_high_lit = 1'b1;
      disp_mode = DM_OFF;
      lamp_on = 1'b0;
      tick_count = '0;
      blink_phase = PH_IDLE;
      shown_code = '0;
      flashes_shown = '0;
      lamp_expect.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HB_PERIOD:    regs.hb_period = cfg_data;
          REG_FLASH_ON:     regs.on_time = cfg_data;
          REG_FLASH_GAP:    regs.gap_time = cfg_data;
          REG_GROUP_PAUSE:  regs.pause_time = cfg_data;
          REG_PIN_HIGH_LIT: regs.pin_high_lit = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_lamp(op_t'(mode), arg);
      if (out_valid && out_ready) begin
        results_seen++;
        if (lamp_expect.size() == 0) begin
          errors++;
          $display("%0t ns: result with no request waiting", $time);
        end else begin
          exp_v = lamp_expect.pop_front();
          compare_field("led_lit", {1'b0, exp_v.lit}, {1'b0, led_lit});
          compare_field("pin_level", {1'b0, exp_v.pin}, {1'b0, pin_level});
          compare_field("display_mode", exp_v.mode, display_mode);
          compare_field("flash_phase", exp_v.ph, flash_phase);
        end
      end
    end
    pending = lamp_expect.size();
  end

endmodule

// ===== verif/led_blink_code_flasher_tb.sv =====
module led_blink_code_flasher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ledbcf_pkg::*;

  localparam int TB_TIME_BITS = 16;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PHASE_COUNT = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            mode = 2'd0;
  logic [7:0]            arg = 8'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  led_lit;
  logic                  pin_level;
  logic [1:0]            display_mode;
  logic [1:0]            flash_phase;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int results_seen;

  // Requests sent, register settings applied, and the switch that turns off idling.
  int sent = 0;
  int settings_done = 0;
  bit quiet = 1'b0;

  always #2 clk = ~clk;

  led_blink_code_flasher #(
    .TIME_BITS(TB_TIME_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .arg(arg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .led_lit(led_lit),
    .pin_level(pin_level),
    .display_mode(display_mode),
    .flash_phase(flash_phase),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  led_blink_code_flasher_checker #(
    .TIME_BITS(TB_TIME_BITS)
  ) lamp_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .arg(arg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .led_lit(led_lit),
    .pin_level(pin_level),
    .display_mode(display_mode),
    .flash_phase(flash_phase),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending),
    .results_seen(results_seen)
  );

  // Send one request. Called at a falling edge; returns at the falling edge
  // after the request is taken, with valid still high so that back-to-back
  // requests never drop it.
  task automatic send_req(input op_t op, input logic [7:0] a);
    // Drop valid for a short burst now and then, except in the quiet tail.
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    mode <= op;
    arg <= a;
    in_valid <= 1'b1;
    // Hold the request until the block takes it.
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  // Stop sending and wait until every expected result has come back, then
  // let the two-stage pipeline settle.
  task automatic drain_pipeline();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Reprogram all timing registers with the block idle.
  task automatic apply_cfg(input logic [15:0] hb, input logic [15:0] on_t,
                           input logic [15:0] gap_t, input logic [15:0] pause_t,
                           input logic ah);
    logic [15:0] ah_word;
    ah_word = 16'($urandom);
    ah_word[0] = ah;
    drain_pipeline();
    write_reg(REG_HB_PERIOD, hb);
    write_reg(REG_FLASH_ON, on_t);
    write_reg(REG_FLASH_GAP, gap_t);
    write_reg(REG_GROUP_PAUSE, pause_t);
    // Upper bits of the polarity write are random; only bit 0 counts.
    write_reg(REG_PIN_HIGH_LIT, ah_word);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Mostly ticks so that flash sequences run deep, with commands mixed in.
  // Codes and modes are usually in the useful range, sometimes anything.
  task automatic send_random();
    int unsigned pick;
    logic [7:0] a;
    pick = $urandom_range(0, 99);
    a = 8'($urandom_range(0, 255));
    if (pick < 68) begin
      send_req(OP_TICK, a);
    end else if (pick < 78) begin
      if ($urandom_range(0, 7) != 0) a = 8'($urandom_range(0, 3));
      send_req(OP_SET_MODE, a);
    end else if (pick < 88) begin
      if ($urandom_range(0, 7) != 0) a = 8'($urandom_range(1, 4));
      send_req(OP_ERROR_CODE, a);
    end else begin
      send_req(OP_FORCE_LED, a);
    end
  endtask

  // Result side: stall now and then, with runs of readiness.
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset timing, mode commands, ignored mode values, force levels.
    send_req(OP_TICK, 8'h00);
    send_req(OP_SET_MODE, 8'd1);
    send_req(OP_FORCE_LED, 8'h00);
    send_req(OP_FORCE_LED, 8'h80);
    send_req(OP_SET_MODE, 8'd4);
    send_req(OP_SET_MODE, 8'hFF);
    send_req(OP_SET_MODE, 8'd0);

    // Short timing, inverted pin.
    apply_cfg(16'd2, 16'd1, 16'd1, 16'd2, 1'b0);
    send_req(OP_SET_MODE, 8'd2);
    send_req(OP_TICK, 8'hFF);
    send_req(OP_TICK, 8'h55);
    // Error mode with no code: ticks keep the LED dark.
    send_req(OP_SET_MODE, 8'd3);
    send_req(OP_TICK, 8'hAA);
    // Code zero behaves as display off.
    send_req(OP_ERROR_CODE, 8'h00);
    send_req(OP_ERROR_CODE, 8'hFF);
    // Force is overridden by the next tick out of idle.
    send_req(OP_FORCE_LED, 8'h01);
    send_req(OP_TICK, 8'h00);
    send_req(OP_TICK, 8'h00);
    send_req(OP_TICK, 8'h00);
    send_req(OP_ERROR_CODE, 8'd1);
    repeat (6) send_req(OP_TICK, 8'h00);
    send_req(OP_FORCE_LED, 8'hFF);

    // Random phases, each under a different register setting.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: apply_cfg(16'd1, 16'd0, 16'd0, 16'd0, 1'b1);
        1: apply_cfg(16'd0, 16'd3, 16'd2, 16'd4, 1'b0);
        2: apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        3: begin
          // Quick flashes with the longest group pause.
          apply_cfg(16'd3, 16'd0, 16'd0, 16'hFFFF, 1'b0);
          send_req(OP_ERROR_CODE, 8'd1);
        end
        default: begin
          if (p == PHASE_COUNT - 1) begin
            // No idling on either side for the tail of the run.
            drain_pipeline();
            quiet = 1'b1;
          end
          apply_cfg(16'($urandom_range(0, 9)), 16'($urandom_range(0, 7)),
                    16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
    end

    drain_pipeline();
    if (pending != 0) $display("%0t ns: %0d results never arrived", $time, pending);
    $display("covered %0d requests and %0d results over %0d register settings",
             sent, results_seen, settings_done);
    $display("mode commands, error codes, forced levels, heartbeat and flash timing");
    if (errors == 0 && pending == 0) begin
      $display("led_blink_code_flasher_tb: done, clean");
    end else begin
      $display("led_blink_code_flasher_tb: done, errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8_000_000;
    $display("led_blink_code_flasher_tb: done, errors");
    $finish;
  end

endmodule
